// File: design/triangle_tangent_generator_assert.svh
// assertion helpers for the rtl, included by ttg_ctrl
`ifndef TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH
`define TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH

// clocked check, masked during reset
`define TTG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, live through reset as well
`define TTG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ttg_pkg.sv
`default_nettype none
package ttg_pkg;

  // field widths
  localparam int PosW   = 24;
  localparam int TexW   = 16;
  localparam int IdxW   = 32;
  localparam int EdgeW  = 25;
  localparam int DeltaW = 17;
  localparam int ProdW  = 42;
  localparam int DetPW  = 34;
  localparam int DetW   = 35;
  localparam int TanW   = 43;
  localparam int MagW   = 31;
  localparam int SumW   = 64;
  localparam int RemW   = 46;
  localparam int QuotW  = 15;
  localparam int OutW   = 16;
  localparam int FracW  = 14;
  localparam int CntW   = 5;

  // iteration counts
  localparam int SquareSteps = 3;
  localparam int RootSteps   = 32;
  localparam int DivSteps    = 15;
  localparam int LastComp    = 2;

  localparam logic [QuotW-1:0] OneQ14    = 15'd16384;
  localparam logic [SumW-1:0]  RootStart = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_MAG,
    ST_NORM,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } ttg_state_t;

  typedef struct packed {
    logic       store_corner;
    logic       corner_sel;
    logic       capture_tri;
    logic       prod_en;
    logic       mag_en;
    logic       shift_right;
    logic       shift_left;
    logic       sq_en;
    logic [1:0] sel;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       div_last;
    logic       out_load;
    logic       out_zero;
  } ttg_cmd_t;

  typedef struct packed {
    logic mag_hi;
    logic mag_lo;
    logic mag_zero;
  } ttg_status_t;

endpackage
`default_nettype wire

// File: design/triangle_tangent_generator.sv
`default_nettype none
// Triangle tangent generator: takes a triangle stream one corner a request (position Q8.16,
// texcoord Q4.12, vertex index) and on every third corner returns one unit tangent in Q1.14
// with w fixed at 1.0 and the three corner indices; a zero tangent comes out as zero. The
// third corner starts a sequenced job: products, magnitudes, normalising shifts (up to 30
// left or 10 right), sum of squares, a bit-serial square root and three bit-serial
// divisions; a zero tangent goes from the shifts straight to the result. New corners are
// taken while a result waits.
module triangle_tangent_generator import ttg_pkg::*; (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic                   in_valid,
  output       logic                   in_ready,
  input  wire  logic signed [PosW-1:0] pos_x,
  input  wire  logic signed [PosW-1:0] pos_y,
  input  wire  logic signed [PosW-1:0] pos_z,
  input  wire  logic signed [TexW-1:0] tex_u,
  input  wire  logic signed [TexW-1:0] tex_v,
  input  wire  logic [IdxW-1:0]        vertex_index,
  output       logic                   out_valid,
  input  wire  logic                   out_ready,
  output       logic signed [OutW-1:0] tangent_x,
  output       logic signed [OutW-1:0] tangent_y,
  output       logic signed [OutW-1:0] tangent_z,
  output       logic [QuotW-1:0]       tangent_w,
  output       logic [IdxW-1:0]        first_corner_index,
  output       logic [IdxW-1:0]        second_corner_index,
  output       logic [IdxW-1:0]        third_corner_index
);

  ttg_cmd_t    cmd;
  ttg_status_t status;

  // sequencer
  ttg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic
  ttg_datapath u_datapath (
    .clk                 (clk),
    .cmd                 (cmd),
    .status              (status),
    .pos_x               (pos_x),
    .pos_y               (pos_y),
    .pos_z               (pos_z),
    .tex_u               (tex_u),
    .tex_v               (tex_v),
    .vertex_index        (vertex_index),
    .tangent_x           (tangent_x),
    .tangent_y           (tangent_y),
    .tangent_z           (tangent_z),
    .tangent_w           (tangent_w),
    .first_corner_index  (first_corner_index),
    .second_corner_index (second_corner_index),
    .third_corner_index  (third_corner_index)
  );

endmodule
`default_nettype wire

// File: design/ttg_datapath.sv
`default_nettype none
module ttg_datapath import ttg_pkg::*; (
  input  wire  logic                   clk,
  input  wire  ttg_cmd_t               cmd,
  output       ttg_status_t            status,
  input  wire  logic signed [PosW-1:0] pos_x,
  input  wire  logic signed [PosW-1:0] pos_y,
  input  wire  logic signed [PosW-1:0] pos_z,
  input  wire  logic signed [TexW-1:0] tex_u,
  input  wire  logic signed [TexW-1:0] tex_v,
  input  wire  logic [IdxW-1:0]        vertex_index,
  output       logic signed [OutW-1:0] tangent_x,
  output       logic signed [OutW-1:0] tangent_y,
  output       logic signed [OutW-1:0] tangent_z,
  output       logic [QuotW-1:0]       tangent_w,
  output       logic [IdxW-1:0]        first_corner_index,
  output       logic [IdxW-1:0]        second_corner_index,
  output       logic [IdxW-1:0]        third_corner_index
);

  logic signed [PosW-1:0]   held_pos [2][3];
  logic signed [TexW-1:0]   held_u [2];
  logic signed [TexW-1:0]   held_v [2];
  logic [IdxW-1:0]          held_idx [2];
  logic [IdxW-1:0]          idx2;
  logic signed [PosW-1:0]   in_pos [3];

  logic signed [EdgeW-1:0]  e0 [3];
  logic signed [EdgeW-1:0]  e1 [3];
  logic signed [DeltaW-1:0] du0, dv0, du1, dv1;
  logic signed [ProdW-1:0]  pa [3];
  logic signed [ProdW-1:0]  pb [3];
  logic signed [DetPW-1:0]  det_a, det_b;
  logic signed [DetW-1:0]   det;
  logic signed [TanW-1:0]   t_raw [3];
  logic signed [TanW-1:0]   t_fix [3];
  logic [TanW-1:0]          mag [3];
  logic                     sgn [3];

  logic [MagW-1:0]          sq_in;
  logic [2*MagW-1:0]        sq_prod;
  logic [SumW-1:0]          acc;
  logic [SumW-1:0]          rt_x, rt_r, rt_b, rt_rb;
  logic [RemW-1:0]          rem, dvs;
  logic [QuotW-1:0]         quo, quo_next;
  logic                     ge;
  logic signed [OutW-1:0]   tan [3];

  assign in_pos[0] = pos_x;
  assign in_pos[1] = pos_y;
  assign in_pos[2] = pos_z;

  // corner storage and edge capture
  always_ff @(posedge clk) begin
    if (cmd.store_corner) begin
      held_pos[cmd.corner_sel][0] <= pos_x;
      held_pos[cmd.corner_sel][1] <= pos_y;
      held_pos[cmd.corner_sel][2] <= pos_z;
      held_u[cmd.corner_sel]      <= tex_u;
      held_v[cmd.corner_sel]      <= tex_v;
      held_idx[cmd.corner_sel]    <= vertex_index;
    end
    if (cmd.capture_tri) begin
      for (int a = 0; a < 3; a++) begin
        e0[a] <= EdgeW'(held_pos[1][a]) - EdgeW'(held_pos[0][a]);
        e1[a] <= EdgeW'(in_pos[a]) - EdgeW'(held_pos[1][a]);
      end
      du0  <= DeltaW'(held_u[1]) - DeltaW'(held_u[0]);
      dv0  <= DeltaW'(held_v[1]) - DeltaW'(held_v[0]);
      du1  <= DeltaW'(tex_u) - DeltaW'(held_u[1]);
      dv1  <= DeltaW'(tex_v) - DeltaW'(held_v[1]);
      idx2 <= vertex_index;
    end
  end

  // tangent and determinant products
  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      for (int a = 0; a < 3; a++) begin
        pa[a] <= ProdW'(dv1 * e0[a]);
        pb[a] <= ProdW'(dv0 * e1[a]);
      end
      det_a <= DetPW'(du0 * dv1);
      det_b <= DetPW'(du1 * dv0);
    end
  end

  // signed tangent, orientation flip, magnitudes
  assign det = DetW'(det_a) - DetW'(det_b);
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      t_raw[a] = TanW'(pa[a]) - TanW'(pb[a]);
      t_fix[a] = det[DetW-1] ? -t_raw[a] : t_raw[a];
    end
  end

  // magnitude registers, also the normalising shifter
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.mag_en) begin
        sgn[a] <= t_fix[a][TanW-1];
        mag[a] <= t_fix[a][TanW-1] ? TanW'(-t_fix[a]) : TanW'(t_fix[a]);
      end else if (cmd.shift_right) begin
        mag[a] <= mag[a] >> 1;
      end else if (cmd.shift_left) begin
        mag[a] <= mag[a] << 1;
      end
    end
  end

  assign status.mag_hi   = |{mag[0][TanW-1:MagW], mag[1][TanW-1:MagW], mag[2][TanW-1:MagW]};
  assign status.mag_lo   = ~|{mag[0][TanW-1:MagW-1], mag[1][TanW-1:MagW-1],
                              mag[2][TanW-1:MagW-1]};
  assign status.mag_zero = ~|{mag[0], mag[1], mag[2]};

  // sum of squares, one component a cycle
  assign sq_in   = mag[cmd.sel][MagW-1:0];
  assign sq_prod = sq_in * sq_in;
  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      acc <= ((cmd.sel == 2'd0) ? '0 : acc) + SumW'(sq_prod);
    end
  end

  // square root, one result bit a cycle
  assign rt_rb = rt_r + rt_b;
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rt_x <= acc;
      rt_r <= '0;
      rt_b <= RootStart;
    end else if (cmd.root_step) begin
      if (rt_x >= rt_rb) begin
        rt_x <= rt_x - rt_rb;
        rt_r <= (rt_r >> 1) + rt_b;
      end else begin
        rt_r <= rt_r >> 1;
      end
      rt_b <= rt_b >> 2;
    end
  end

  // rounded division, one quotient bit a cycle
  assign ge       = rem >= dvs;
  assign quo_next = {quo[QuotW-2:0], ge};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= {mag[cmd.sel][MagW-1:0], {FracW{1'b0}}} + RemW'(rt_r[31:1]);
      dvs <= {rt_r[31:0], {FracW{1'b0}}};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      dvs <= dvs >> 1;
      quo <= quo_next;
      if (cmd.div_last) begin
        tan[cmd.sel] <= sgn[cmd.sel] ? -OutW'(quo_next) : OutW'(quo_next);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tangent_x           <= cmd.out_zero ? '0 : tan[0];
      tangent_y           <= cmd.out_zero ? '0 : tan[1];
      tangent_z           <= cmd.out_zero ? '0 : tan[2];
      first_corner_index  <= held_idx[0];
      second_corner_index <= held_idx[1];
      third_corner_index  <= idx2;
    end
  end

  assign tangent_w = OneQ14;

endmodule
`default_nettype wire

// File: design/ttg_ctrl.sv
`default_nettype none
`include "triangle_tangent_generator_assert.svh"
module ttg_ctrl import ttg_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output       logic        in_ready,
  output       logic        out_valid,
  input  wire  logic        out_ready,
  input  wire  ttg_status_t status,
  output       ttg_cmd_t    cmd
);

  ttg_state_t      state, state_next;
  logic [1:0]      corner_count;
  logic [CntW-1:0] cnt;
  logic [1:0]      comp;
  logic            zero_tri;
  logic            in_acc;
  logic            cnt_last_sq, cnt_last_root, cnt_last_div;

  assign in_acc        = in_valid && in_ready;
  assign cnt_last_sq   = cnt == CntW'(SquareSteps - 1);
  assign cnt_last_root = cnt == CntW'(RootSteps - 1);
  assign cnt_last_div  = cnt == CntW'(DivSteps - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid && corner_count == 2'd2) state_next = ST_PROD;
      ST_PROD:      state_next = ST_MAG;
      ST_MAG:       state_next = ST_NORM;
      ST_NORM: begin
        if (status.mag_zero) state_next = ST_DONE;
        else if (!status.mag_hi && !status.mag_lo) state_next = ST_SQUARE;
      end
      ST_SQUARE:    if (cnt_last_sq) state_next = ST_ROOT_INIT;
      ST_ROOT_INIT: state_next = ST_ROOT;
      ST_ROOT:      if (cnt_last_root) state_next = ST_DIV_INIT;
      ST_DIV_INIT:  state_next = ST_DIV;
      ST_DIV: begin
        if (cnt_last_div) state_next = (comp == 2'(LastComp)) ? ST_DONE : ST_DIV_INIT;
      end
      ST_DONE:      if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    cmd.out_zero = zero_tri;
    cmd.sel      = comp;
    case (state)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.corner_sel   = corner_count[0];
        cmd.store_corner = in_valid && corner_count != 2'd2;
        cmd.capture_tri  = in_valid && corner_count == 2'd2;
      end
      ST_PROD:      cmd.prod_en = 1'b1;
      ST_MAG:       cmd.mag_en = 1'b1;
      ST_NORM: begin
        cmd.shift_right = !status.mag_zero && status.mag_hi;
        cmd.shift_left  = !status.mag_zero && status.mag_lo;
      end
      ST_SQUARE: begin
        cmd.sq_en = 1'b1;
        cmd.sel   = cnt[1:0];
      end
      ST_ROOT_INIT: cmd.root_init = 1'b1;
      ST_ROOT:      cmd.root_step = 1'b1;
      ST_DIV_INIT:  cmd.div_init = 1'b1;
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = cnt_last_div;
      end
      ST_DONE:      cmd.out_load = !out_valid || out_ready;
      default:      cmd = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      corner_count <= '0;
      cnt          <= '0;
      comp         <= '0;
      zero_tri     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CntW'(1);
      if (in_acc) begin
        corner_count <= (corner_count == 2'd2) ? 2'd0 : corner_count + 2'd1;
      end
      if (state == ST_ROOT_INIT) begin
        comp <= '0;
      end else if (state == ST_DIV && cnt_last_div) begin
        comp <= comp + 2'd1;
      end
      if (state == ST_NORM) begin
        zero_tri <= status.mag_zero;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TTG_ASSERT(a_count_range, corner_count != 2'd3, "corner count out of range")
  `TTG_ASSERT(a_tri_starts, in_acc && corner_count == 2'd2 |=> state == ST_PROD, "triangle not started")
  `TTG_ASSERT(a_done_holds, state == ST_DONE && out_valid && !out_ready |=> state == ST_DONE, "result overwritten")
  `TTG_ASSERT(a_root_len, state == ST_ROOT && cnt_last_root |=> state == ST_DIV_INIT, "root length wrong")
  `TTG_ASSERT_ALWAYS(a_reset_idle, rst |=> state == ST_IDLE && !out_valid, "reset not idle")

endmodule
`default_nettype wire
